FILE: hdl/balanced_kmeans_assign_update_defines.svh
// Assertion macros shared by the balanced k-means block.
// Depends on a clock named i_clk and an active-low reset named i_rst_n in scope.
`ifndef BALANCED_KMEANS_ASSIGN_UPDATE_DEFINES_SVH
`define BALANCED_KMEANS_ASSIGN_UPDATE_DEFINES_SVH

// Consequent checked in the same cycle as the antecedent.
`define BKM_ASSERT_NOW(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Consequent checked in the cycle after the antecedent.
`define BKM_ASSERT_NEXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

FILE: hdl/bkm_pkg.sv
// Shared constants, codes and controller/datapath command types of the k-means block.
// No dependencies.
package bkm_pkg;

    localparam int CLUSTERS = 16;
    localparam int DIMS     = 16;
    localparam int CW       = 4;
    localparam int DW       = 4;
    localparam int AW       = CW + DW;
    localparam int VAL_W    = 16;
    localparam int DIST_W   = 36;
    localparam int PEN_W    = 37;
    localparam int SUM_W    = 37;
    localparam int CNT_W    = 21;
    localparam int TOT_W    = 63;
    localparam int EMPTY_W  = 5;
    localparam int WGT_W    = 16;

    localparam logic [CNT_W-1:0] MAX_ROWS = 21'd1048576;

    localparam logic [1:0] KIND_LOAD   = 2'd0;
    localparam logic [1:0] KIND_SAMPLE = 2'd1;
    localparam logic [1:0] KIND_END    = 2'd2;
    localparam logic [1:0] KIND_READ   = 2'd3;

    localparam logic [1:0] RES_ROW  = 2'd0;
    localparam logic [1:0] RES_PASS = 2'd1;
    localparam logic [1:0] RES_READ = 2'd2;

    typedef struct packed {
        logic          cent_load;
        logic          row_wr;
        logic          cent_rd_user;
        logic          dist_rd;
        logic          dist_first;
        logic          dist_last;
        logic          upd_rd;
        logic          sum_rd;
        logic          div_start;
        logic          cent_wr_mean;
        logic          mean_empty;
        logic          row_emit;
        logic          rd_emit;
        logic          pass_end;
        logic [CW-1:0] c;
        logic [DW-1:0] d;
    } t_cmd;

    typedef struct packed {
        logic out_free;
        logic dist_done;
        logic div_busy;
        logic cnt_zero;
    } t_status;

endpackage

FILE: hdl/bkm_div.sv
// Restoring divider, one quotient bit per cycle, for the rounded centroid means.
// Depends on bkm_pkg for operand widths.
module bkm_div (
    input  logic                       i_clk,
    input  logic                       i_rst_n,
    input  logic                       i_start,
    input  logic [bkm_pkg::SUM_W-1:0]  i_num,
    input  logic [bkm_pkg::CNT_W-1:0]  i_den,
    output logic                       o_busy,
    output logic [bkm_pkg::SUM_W-1:0]  o_quo
);
    localparam int NW = bkm_pkg::SUM_W;
    localparam int DNW = bkm_pkg::CNT_W;
    localparam int CB = $clog2(NW);

    logic [DNW-1:0] r_rem, n_rem;
    logic [DNW-1:0] r_den;
    logic [NW-1:0]  r_quo;
    logic [CB-1:0]  r_cnt;
    logic           r_busy;
    logic [DNW:0]   rem_sh, rem_sub;
    logic           ge;

    always_comb begin
        rem_sh  = {r_rem, r_quo[NW-1]};
        rem_sub = rem_sh - {1'b0, r_den};
        ge      = rem_sh >= {1'b0, r_den};
        n_rem   = ge ? rem_sub[DNW-1:0] : rem_sh[DNW-1:0];
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_cnt  <= '0;
        end else if (i_start) begin
            r_busy <= 1'b1;
            r_cnt  <= CB'(NW - 1);
        end else if (r_busy) begin
            if (r_cnt == '0) begin
                r_busy <= 1'b0;
            end
            r_cnt <= r_cnt - 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_rem <= '0;
            r_den <= i_den;
            r_quo <= i_num;
        end else if (r_busy) begin
            r_rem <= n_rem;
            r_quo <= {r_quo[NW-2:0], ge};
        end
    end

    assign o_busy = r_busy;
    assign o_quo  = r_quo;
endmodule

FILE: hdl/bkm_datapath.sv
// Datapath: centroid and sum memories, row buffer, distance pipeline, counts,
// totals and the output register. Depends on bkm_pkg and bkm_div.
module bkm_datapath (
    input  logic                               i_clk,
    input  logic                               i_rst_n,
    input  bkm_pkg::t_cmd                      i_cmd,
    output bkm_pkg::t_status                   o_status,
    input  logic [bkm_pkg::WGT_W-1:0]          i_weight,
    input  logic [bkm_pkg::CW-1:0]             i_cluster_index,
    input  logic [bkm_pkg::DW-1:0]             i_dim_index,
    input  logic signed [bkm_pkg::VAL_W-1:0]   i_value,
    input  logic                               i_ready,
    output logic                               o_valid,
    output logic [1:0]                         o_result_kind,
    output logic [bkm_pkg::CW-1:0]             o_best_cluster,
    output logic [bkm_pkg::DIST_W-1:0]         o_row_distance,
    output logic [bkm_pkg::PEN_W-1:0]          o_row_penalized,
    output logic signed [bkm_pkg::VAL_W-1:0]   o_centroid_value,
    output logic [bkm_pkg::TOT_W-1:0]          o_total_fit,
    output logic [bkm_pkg::TOT_W-1:0]          o_total_sse,
    output logic [bkm_pkg::EMPTY_W-1:0]        o_empty_clusters
);
    localparam int NC = bkm_pkg::CLUSTERS;
    localparam int ND = bkm_pkg::DIMS;
    localparam int CW = bkm_pkg::CW;
    localparam int AW = bkm_pkg::AW;
    localparam int VW = bkm_pkg::VAL_W;
    localparam int SW = bkm_pkg::SUM_W;
    localparam int NW = bkm_pkg::CNT_W;
    localparam int TW = bkm_pkg::TOT_W;
    localparam int PW = bkm_pkg::PEN_W;
    localparam int XW = bkm_pkg::DIST_W;
    localparam int MW = bkm_pkg::WGT_W + NW;
    localparam logic [XW-1:0] DIST_MAX = '1;
    localparam logic [TW-1:0] TOT_MAX = '1;

    typedef struct packed {
        logic          v;
        logic          first;
        logic          last;
        logic [CW-1:0] c;
    } t_tag;

    // Memories and stores.
    logic signed [VW-1:0] r_cent_mem [NC*ND];
    logic [SW-1:0]        r_sum_mem [NC*ND];
    logic [NC*ND-1:0]     r_sum_vld;
    logic signed [VW-1:0] r_row [ND];
    logic [NW-1:0]        r_mcnt [NC];
    logic [NW-1:0]        r_pcnt [NC];

    logic signed [VW-1:0] r_cent_q, r_row_q;
    logic [SW-1:0]        r_sum_q;
    logic                 r_sumv_q;

    // Distance pipeline.
    t_tag            r_p1, r_p2, r_p3, r_p4;
    logic [31:0]     r_sq;
    logic [XW-1:0]   r_acc, r_dfin;
    logic [PW-1:0]   r_tot;
    logic [MW-9:0]   r_pen, r_pen2;
    logic [CW-1:0]   r_best_c;
    logic [PW-1:0]   r_best_pen;
    logic [XW-1:0]   r_best_dist;

    // Sum update stage.
    logic            r_u1_v;
    logic [bkm_pkg::DW-1:0] r_u1_d;

    logic [TW-1:0]   r_fit, r_sse;
    logic [bkm_pkg::EMPTY_W-1:0] r_empty;
    logic            r_out_v;
    logic            r_div_neg;

    logic            out_free;
    logic            cent_we;
    logic [AW-1:0]   cent_waddr, cent_raddr;
    logic signed [VW-1:0] cent_wdata;
    logic [AW-1:0]   sum_raddr, upd_addr;
    logic [SW-1:0]   sum_eff, sum_mag, div_num, sum_new;
    logic [SW:0]     sum_ext;
    logic signed [VW:0] diff;
    logic [VW-1:0]   adiff;
    logic [XW:0]     acc_sum;
    logic [MW-1:0]   pen_prod;
    logic            div_busy;
    logic [SW-1:0]   div_quo;
    logic [NW-1:0]   mean_n;
    logic [TW:0]     fit_sum, sse_sum;

    assign out_free = !r_out_v || i_ready;
    assign mean_n   = r_mcnt[i_cmd.c];

    // Centroid memory port selection.
    always_comb begin
        cent_we    = i_cmd.cent_load || i_cmd.cent_wr_mean;
        cent_waddr = i_cmd.cent_load ? {i_cluster_index, i_dim_index} : {i_cmd.c, i_cmd.d};
        if (i_cmd.cent_load) begin
            cent_wdata = i_value;
        end else if (r_div_neg) begin
            cent_wdata = (div_quo > SW'(1 << (VW - 1))) ? {1'b1, {(VW-1){1'b0}}}
                                                       : -div_quo[VW-1:0];
        end else begin
            cent_wdata = (div_quo > SW'((1 << (VW - 1)) - 1)) ? {1'b0, {(VW-1){1'b1}}}
                                                             : div_quo[VW-1:0];
        end
        cent_raddr = i_cmd.dist_rd ? {i_cmd.c, i_cmd.d} : {i_cluster_index, i_dim_index};
    end

    always_ff @(posedge i_clk) begin
        if (cent_we) begin
            r_cent_mem[cent_waddr] <= cent_wdata;
        end
        if (i_cmd.dist_rd || i_cmd.cent_rd_user) begin
            r_cent_q <= r_cent_mem[cent_raddr];
        end
    end

    // Row buffer.
    always_ff @(posedge i_clk) begin
        if (i_cmd.row_wr) begin
            r_row[i_dim_index] <= i_value;
        end
        if (i_cmd.dist_rd || i_cmd.upd_rd) begin
            r_row_q <= r_row[i_cmd.d];
        end
    end

    // Sum memory with per-entry valid bits; an entry that is not valid reads as zero.
    assign sum_raddr = i_cmd.upd_rd ? {r_best_c, i_cmd.d} : {i_cmd.c, i_cmd.d};
    assign upd_addr  = {r_best_c, r_u1_d};
    assign sum_eff   = r_sumv_q ? r_sum_q : '0;

    always_comb begin
        sum_ext = {sum_eff[SW-1], sum_eff} + {{(SW+1-VW){r_row_q[VW-1]}}, r_row_q};
        if (sum_ext[SW] != sum_ext[SW-1]) begin
            sum_new = sum_ext[SW] ? {1'b1, {(SW-1){1'b0}}} : {1'b0, {(SW-1){1'b1}}};
        end else begin
            sum_new = sum_ext[SW-1:0];
        end
        sum_mag = sum_eff[SW-1] ? -sum_eff : sum_eff;
        div_num = sum_mag + SW'(mean_n >> 1);
    end

    always_ff @(posedge i_clk) begin
        if (r_u1_v) begin
            r_sum_mem[upd_addr] <= sum_new;
        end
        if (i_cmd.upd_rd || i_cmd.sum_rd) begin
            r_sum_q <= r_sum_mem[sum_raddr];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_sum_vld <= '0;
            r_sumv_q  <= 1'b0;
            r_u1_v    <= 1'b0;
        end else begin
            r_u1_v <= i_cmd.upd_rd;
            if (i_cmd.upd_rd || i_cmd.sum_rd) begin
                r_sumv_q <= r_sum_vld[sum_raddr];
            end
            if (i_cmd.pass_end) begin
                r_sum_vld <= '0;
            end else if (r_u1_v) begin
                r_sum_vld[upd_addr] <= 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        r_u1_d <= i_cmd.d;
    end

    // Distance pipeline: read, square, accumulate, add penalty, compare.
    always_comb begin
        diff     = {r_row_q[VW-1], r_row_q} - {r_cent_q[VW-1], r_cent_q};
        adiff    = diff[VW] ? VW'(-diff) : diff[VW-1:0];
        acc_sum  = {1'b0, r_acc} + (XW+1)'(r_sq);
        pen_prod = {{NW{1'b0}}, i_weight} * {{bkm_pkg::WGT_W{1'b0}}, r_pcnt[r_p1.c]};
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_p1 <= '0;
            r_p2 <= '0;
            r_p3 <= '0;
            r_p4 <= '0;
        end else begin
            r_p1 <= '{v: i_cmd.dist_rd, first: i_cmd.dist_first, last: i_cmd.dist_last,
                      c: i_cmd.c};
            r_p2 <= r_p1;
            r_p3 <= r_p2;
            r_p4 <= '{v: r_p3.v && r_p3.last, first: r_p3.first, last: r_p3.last,
                      c: r_p3.c};
        end
    end

    always_ff @(posedge i_clk) begin
        r_sq <= 32'(adiff) * 32'(adiff);
        if (r_p1.v && r_p1.first) begin
            r_pen <= pen_prod[MW-1:8];
        end
        if (r_p2.v) begin
            if (r_p2.first) begin
                r_acc <= XW'(r_sq);
            end else begin
                r_acc <= (acc_sum > (XW+1)'(DIST_MAX)) ? DIST_MAX : acc_sum[XW-1:0];
            end
            if (r_p2.last) begin
                r_pen2 <= r_pen;
            end
        end
        if (r_p3.v && r_p3.last) begin
            r_tot  <= PW'(r_acc) + PW'(r_pen2);
            r_dfin <= r_acc;
        end
        if (r_p4.v && (r_p4.c == '0 || r_tot < r_best_pen)) begin
            r_best_c    <= r_p4.c;
            r_best_pen  <= r_tot;
            r_best_dist <= r_dfin;
        end
    end

    // Divider for the rounded means.
    always_ff @(posedge i_clk) begin
        if (i_cmd.div_start) begin
            r_div_neg <= sum_eff[SW-1];
        end
    end

    bkm_div u_div (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (i_cmd.div_start),
        .i_num   (div_num),
        .i_den   (mean_n),
        .o_busy  (div_busy),
        .o_quo   (div_quo)
    );

    // Counts and totals.
    assign fit_sum = {1'b0, r_fit} + (TW+1)'(r_best_pen);
    assign sse_sum = {1'b0, r_sse} + (TW+1)'(r_best_dist);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_fit   <= '0;
            r_sse   <= '0;
            r_empty <= '0;
            for (int i = 0; i < NC; i++) begin
                r_mcnt[i] <= '0;
                r_pcnt[i] <= '0;
            end
        end else begin
            if (i_cmd.row_emit) begin
                r_fit <= fit_sum[TW] ? TOT_MAX : fit_sum[TW-1:0];
                r_sse <= sse_sum[TW] ? TOT_MAX : sse_sum[TW-1:0];
                if (r_mcnt[r_best_c] < bkm_pkg::MAX_ROWS) begin
                    r_mcnt[r_best_c] <= r_mcnt[r_best_c] + 1'b1;
                end
            end
            if (i_cmd.mean_empty) begin
                r_empty <= r_empty + 1'b1;
            end
            if (i_cmd.pass_end) begin
                r_fit   <= '0;
                r_sse   <= '0;
                r_empty <= '0;
                for (int i = 0; i < NC; i++) begin
                    r_pcnt[i] <= r_mcnt[i];
                    r_mcnt[i] <= '0;
                end
            end
        end
    end

    // Output register.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_v <= 1'b0;
        end else if (i_cmd.row_emit || i_cmd.rd_emit || i_cmd.pass_end) begin
            r_out_v <= 1'b1;
        end else if (i_ready) begin
            r_out_v <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.row_emit || i_cmd.rd_emit || i_cmd.pass_end) begin
            o_result_kind    <= bkm_pkg::RES_ROW;
            o_best_cluster   <= '0;
            o_row_distance   <= '0;
            o_row_penalized  <= '0;
            o_centroid_value <= '0;
            o_total_fit      <= '0;
            o_total_sse      <= '0;
            o_empty_clusters <= '0;
            if (i_cmd.row_emit) begin
                o_best_cluster  <= r_best_c;
                o_row_distance  <= r_best_dist;
                o_row_penalized <= r_best_pen;
            end else if (i_cmd.rd_emit) begin
                o_result_kind    <= bkm_pkg::RES_READ;
                o_centroid_value <= r_cent_q;
            end else begin
                o_result_kind    <= bkm_pkg::RES_PASS;
                o_total_fit      <= r_fit;
                o_total_sse      <= r_sse;
                o_empty_clusters <= r_empty;
            end
        end
    end

    assign o_valid = r_out_v;

    assign o_status = '{out_free: out_free,
                        dist_done: r_p4.v && (r_p4.c == CW'(NC - 1)),
                        div_busy: div_busy,
                        cnt_zero: (mean_n == '0)};
endmodule

FILE: hdl/bkm_ctrl.sv
// Controller state machine: sequences loads, readbacks, the per-row distance search,
// the sum update and the end-of-pass mean sweep. Depends on bkm_pkg.
module bkm_ctrl (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_valid,
    input  logic [1:0]            i_kind,
    input  logic                  i_last_in_row,
    output logic                  o_ready,
    input  bkm_pkg::t_status      i_status,
    output bkm_pkg::t_cmd         o_cmd
);
    localparam int CW = bkm_pkg::CW;
    localparam int DW = bkm_pkg::DW;
    localparam logic [CW-1:0] C_LAST = CW'(bkm_pkg::CLUSTERS - 1);
    localparam logic [DW-1:0] D_LAST = DW'(bkm_pkg::DIMS - 1);

    localparam logic [3:0] S_IDLE    = 4'd0;
    localparam logic [3:0] S_DIST    = 4'd1;
    localparam logic [3:0] S_DRAIN   = 4'd2;
    localparam logic [3:0] S_UPD     = 4'd3;
    localparam logic [3:0] S_ROWEMIT = 4'd4;
    localparam logic [3:0] S_REMIT   = 4'd5;
    localparam logic [3:0] S_MCHK    = 4'd6;
    localparam logic [3:0] S_MRD     = 4'd7;
    localparam logic [3:0] S_MDIV    = 4'd8;
    localparam logic [3:0] S_MWAIT   = 4'd9;
    localparam logic [3:0] S_PEMIT   = 4'd10;

    logic [3:0]    r_state, n_state;
    logic [CW-1:0] r_c, n_c;
    logic [DW-1:0] r_d, n_d;
    logic          accept;

    assign o_ready = (r_state == S_IDLE);
    assign accept  = i_valid && o_ready;

    always_comb begin
        n_state = r_state;
        n_c     = r_c;
        n_d     = r_d;
        o_cmd   = '0;
        o_cmd.c = r_c;
        o_cmd.d = r_d;
        unique case (r_state)
            S_IDLE: begin
                if (accept) begin
                    unique case (i_kind)
                        bkm_pkg::KIND_LOAD: o_cmd.cent_load = 1'b1;
                        bkm_pkg::KIND_SAMPLE: begin
                            o_cmd.row_wr = 1'b1;
                            if (i_last_in_row) begin
                                n_c     = '0;
                                n_d     = '0;
                                n_state = S_DIST;
                            end
                        end
                        bkm_pkg::KIND_END: begin
                            n_c     = '0;
                            n_d     = '0;
                            n_state = S_MCHK;
                        end
                        default: begin
                            o_cmd.cent_rd_user = 1'b1;
                            n_state            = S_REMIT;
                        end
                    endcase
                end
            end
            S_DIST: begin
                o_cmd.dist_rd    = 1'b1;
                o_cmd.dist_first = (r_d == '0);
                o_cmd.dist_last  = (r_d == D_LAST);
                n_d              = r_d + 1'b1;
                if (r_d == D_LAST) begin
                    n_d = '0;
                    n_c = r_c + 1'b1;
                    if (r_c == C_LAST) begin
                        n_state = S_DRAIN;
                    end
                end
            end
            S_DRAIN: begin
                if (i_status.dist_done) begin
                    n_d     = '0;
                    n_state = S_UPD;
                end
            end
            S_UPD: begin
                o_cmd.upd_rd = 1'b1;
                n_d          = r_d + 1'b1;
                if (r_d == D_LAST) begin
                    n_state = S_ROWEMIT;
                end
            end
            S_ROWEMIT: begin
                if (i_status.out_free) begin
                    o_cmd.row_emit = 1'b1;
                    n_state        = S_IDLE;
                end
            end
            S_REMIT: begin
                if (i_status.out_free) begin
                    o_cmd.rd_emit = 1'b1;
                    n_state       = S_IDLE;
                end
            end
            S_MCHK: begin
                n_d = '0;
                if (i_status.cnt_zero) begin
                    o_cmd.mean_empty = 1'b1;
                    n_c              = r_c + 1'b1;
                    if (r_c == C_LAST) begin
                        n_state = S_PEMIT;
                    end
                end else begin
                    n_state = S_MRD;
                end
            end
            S_MRD: begin
                o_cmd.sum_rd = 1'b1;
                n_state      = S_MDIV;
            end
            S_MDIV: begin
                o_cmd.div_start = 1'b1;
                n_state         = S_MWAIT;
            end
            S_MWAIT: begin
                if (!i_status.div_busy) begin
                    o_cmd.cent_wr_mean = 1'b1;
                    n_d                = r_d + 1'b1;
                    n_state            = S_MRD;
                    if (r_d == D_LAST) begin
                        n_c     = r_c + 1'b1;
                        n_state = (r_c == C_LAST) ? S_PEMIT : S_MCHK;
                    end
                end
            end
            S_PEMIT: begin
                if (i_status.out_free) begin
                    o_cmd.pass_end = 1'b1;
                    n_state        = S_IDLE;
                end
            end
            default: n_state = S_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_c     <= '0;
            r_d     <= '0;
        end else begin
            r_state <= n_state;
            r_c     <= n_c;
            r_d     <= n_d;
        end
    end
endmodule

FILE: hdl/balanced_kmeans_assign_update.sv
// Top level of the balanced k-means assign-and-update block: APB register,
// controller and datapath. Depends on bkm_pkg, bkm_ctrl, bkm_datapath and the defines header.
//
//   Channel   Direction  Handshake           Carries
//   input     in         i_valid / o_ready   kind, cluster/dim index, value, last mark
//   output    out        o_valid / i_ready   row assignment, pass summary or readback
//   config    in         APB psel/penable    penalty_weight at byte address 0
//
// Loads and non-final sample elements are taken while the controller stays idle; a readback
// also waits for the output slot. For a final sample element one distance unit walks all 256
// centroid elements, then the 16 sums of the chosen cluster are updated.
// At end of pass each element of a non-empty cluster goes through the
// one-bit-per-cycle divider; an empty cluster is only counted and skipped.
// Reset is synchronous and active low; the sums need no clearing pass. A result waiting
// in the output register stalls the next result, and no item is accepted during that stall.
`include "balanced_kmeans_assign_update_defines.svh"

module balanced_kmeans_assign_update (
    input  logic                               i_clk,
    input  logic                               i_rst_n,
    input  logic                               i_valid,
    output logic                               o_ready,
    input  logic [1:0]                         i_kind,
    input  logic [bkm_pkg::CW-1:0]             i_cluster_index,
    input  logic [bkm_pkg::DW-1:0]             i_dim_index,
    input  logic signed [bkm_pkg::VAL_W-1:0]   i_value,
    input  logic                               i_last_in_row,
    output logic                               o_valid,
    input  logic                               i_ready,
    output logic [1:0]                         o_result_kind,
    output logic [bkm_pkg::CW-1:0]             o_best_cluster,
    output logic [bkm_pkg::DIST_W-1:0]         o_row_distance,
    output logic [bkm_pkg::PEN_W-1:0]          o_row_penalized,
    output logic signed [bkm_pkg::VAL_W-1:0]   o_centroid_value,
    output logic [bkm_pkg::TOT_W-1:0]          o_total_fit,
    output logic [bkm_pkg::TOT_W-1:0]          o_total_sse,
    output logic [bkm_pkg::EMPTY_W-1:0]        o_empty_clusters,
    input  logic                               psel,
    input  logic                               penable,
    input  logic                               pwrite,
    input  logic [2:0]                         paddr,
    input  logic [31:0]                        pwdata,
    output logic [31:0]                        prdata,
    output logic                               pready
);
    logic [bkm_pkg::WGT_W-1:0] r_weight;
    bkm_pkg::t_cmd             cmd;
    bkm_pkg::t_status          status;

    assign pready = 1'b1;
    assign prdata = (paddr[2] == 1'b0) ? {16'd0, r_weight} : 32'd0;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_weight <= '0;
        end else if (psel && penable && pwrite && pready && (paddr[2] == 1'b0)) begin
            r_weight <= pwdata[bkm_pkg::WGT_W-1:0];
        end
    end

    bkm_ctrl u_ctrl (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_valid       (i_valid),
        .i_kind        (i_kind),
        .i_last_in_row (i_last_in_row),
        .o_ready       (o_ready),
        .i_status      (status),
        .o_cmd         (cmd)
    );

    bkm_datapath u_dp (
        .i_clk            (i_clk),
        .i_rst_n          (i_rst_n),
        .i_cmd            (cmd),
        .o_status         (status),
        .i_weight         (r_weight),
        .i_cluster_index  (i_cluster_index),
        .i_dim_index      (i_dim_index),
        .i_value          (i_value),
        .i_ready          (i_ready),
        .o_valid          (o_valid),
        .o_result_kind    (o_result_kind),
        .o_best_cluster   (o_best_cluster),
        .o_row_distance   (o_row_distance),
        .o_row_penalized  (o_row_penalized),
        .o_centroid_value (o_centroid_value),
        .o_total_fit      (o_total_fit),
        .o_total_sse      (o_total_sse),
        .o_empty_clusters (o_empty_clusters)
    );

    // The penalised score of a row can never fall below its pure distance.
    `BKM_ASSERT_NOW(a_pen_ge_dist, o_valid && o_result_kind == bkm_pkg::RES_ROW, o_row_penalized >= 37'(o_row_distance), "penalised distance below pure distance")
    // No more clusters can be empty than exist.
    `BKM_ASSERT_NOW(a_empty_range, o_valid && o_result_kind == bkm_pkg::RES_PASS, o_empty_clusters <= 5'(bkm_pkg::CLUSTERS), "empty cluster count out of range")
    // An end-of-pass item always starts the mean sweep.
    `BKM_ASSERT_NEXT(a_pass_busy, i_valid && o_ready && i_kind == bkm_pkg::KIND_END, !o_ready, "end of pass did not start the mean sweep")
endmodule

FILE: dv/balanced_kmeans_assign_update_tb.sv
// Self-checking testbench for the balanced k-means assign-and-update block.
// Depends on bkm_pkg and the balanced_kmeans_assign_update RTL; nothing else.
`timescale 1ns / 100ps

typedef struct packed {
    logic [1:0]                        kind;
    logic [bkm_pkg::CW-1:0]            best;
    logic [bkm_pkg::DIST_W-1:0]        rdist;
    logic [bkm_pkg::PEN_W-1:0]         pen;
    logic signed [bkm_pkg::VAL_W-1:0]  cval;
    logic [bkm_pkg::TOT_W-1:0]         fit;
    logic [bkm_pkg::TOT_W-1:0]         sse;
    logic [bkm_pkg::EMPTY_W-1:0]       empty;
} t_kmeans_result;

class kmeans_pass_scoreboard;
    longint          centroids [bkm_pkg::CLUSTERS*bkm_pkg::DIMS];
    longint          row_elems [bkm_pkg::DIMS];
    longint          sums [bkm_pkg::CLUSTERS*bkm_pkg::DIMS];
    int unsigned     members [bkm_pkg::CLUSTERS];
    int unsigned     prev_members [bkm_pkg::CLUSTERS];
    longint unsigned fit_total;
    longint unsigned sse_total;
    longint unsigned weight;
    t_kmeans_result  awaited [$];
    int              fails;

    function new();
        foreach (centroids[i]) begin
            centroids[i] = 0;
            sums[i] = 0;
        end
        foreach (row_elems[i]) row_elems[i] = 0;
        foreach (members[i]) begin
            members[i] = 0;
            prev_members[i] = 0;
        end
        fit_total = 0;
        sse_total = 0;
        weight = 0;
        fails = 0;
    endfunction

    function longint unsigned sat(longint unsigned a, longint unsigned b, longint unsigned lim);
        longint unsigned r;
        r = a + b;
        if (r < a || r > lim) r = lim;
        return r;
    endfunction

    function longint rounded_mean(longint s, int unsigned n);
        longint unsigned mag;
        longint r;
        mag = (s < 0) ? -s : s;
        r = (mag + n / 2) / n;
        if (s < 0) r = -r;
        if (r < -32768) r = -32768;
        if (r > 32767) r = 32767;
        return r;
    endfunction

    function void note_item(logic [1:0] kind, logic [3:0] ci, logic [3:0] di,
                            logic signed [15:0] val, logic last);
        t_kmeans_result  r;
        longint unsigned cdist, pen, tot, best_pen, best_dist, ad, acc;
        longint          diff, s;
        int              best, empty;
        r = '0;
        case (kind)
            bkm_pkg::KIND_LOAD: centroids[{ci, di}] = val;
            bkm_pkg::KIND_READ: begin
                r.kind = bkm_pkg::RES_READ;
                r.cval = 16'(centroids[{ci, di}]);
                awaited.push_back(r);
            end
            bkm_pkg::KIND_SAMPLE: begin
                row_elems[di] = val;
                if (last) begin
                    best = 0;
                    best_pen = 0;
                    best_dist = 0;
                    for (int c = 0; c < bkm_pkg::CLUSTERS; c++) begin
                        acc = 0;
                        for (int d = 0; d < bkm_pkg::DIMS; d++) begin
                            diff = row_elems[d] - centroids[c*bkm_pkg::DIMS+d];
                            ad = (diff < 0) ? -diff : diff;
                            acc = sat(acc, ad * ad, (64'd1 << 36) - 1);
                        end
                        cdist = acc;
                        pen = (weight * prev_members[c]) >> 8;
                        tot = sat(cdist, pen, (64'd1 << 37) - 1);
                        if (c == 0 || tot < best_pen) begin
                            best = c;
                            best_pen = tot;
                            best_dist = cdist;
                        end
                    end
                    fit_total = sat(fit_total, best_pen, (64'd1 << 63) - 1);
                    sse_total = sat(sse_total, best_dist, (64'd1 << 63) - 1);
                    if (members[best] < bkm_pkg::MAX_ROWS) members[best]++;
                    for (int d = 0; d < bkm_pkg::DIMS; d++) begin
                        s = sums[best*bkm_pkg::DIMS+d] + row_elems[d];
                        if (s > (64'sd1 << 36) - 1) s = (64'sd1 << 36) - 1;
                        if (s < -(64'sd1 << 36)) s = -(64'sd1 << 36);
                        sums[best*bkm_pkg::DIMS+d] = s;
                    end
                    r.kind = bkm_pkg::RES_ROW;
                    r.best = 4'(best);
                    r.rdist = 36'(best_dist);
                    r.pen = 37'(best_pen);
                    awaited.push_back(r);
                end
            end
            default: begin
                empty = 0;
                for (int c = 0; c < bkm_pkg::CLUSTERS; c++) begin
                    if (members[c] == 0) empty++;
                    else for (int d = 0; d < bkm_pkg::DIMS; d++)
                        centroids[c*bkm_pkg::DIMS+d] =
                            rounded_mean(sums[c*bkm_pkg::DIMS+d], members[c]);
                    prev_members[c] = members[c];
                    members[c] = 0;
                end
                foreach (sums[i]) sums[i] = 0;
                r.kind = bkm_pkg::RES_PASS;
                r.fit = 63'(fit_total);
                r.sse = 63'(sse_total);
                r.empty = 5'((empty > 31) ? 31 : empty);
                awaited.push_back(r);
                fit_total = 0;
                sse_total = 0;
            end
        endcase
    endfunction

    function void check_result(t_kmeans_result got);
        t_kmeans_result e;
        if (awaited.size() == 0) begin
            $error("result with no expectation: kind %0d", got.kind);
            fails++;
            return;
        end
        e = awaited.pop_front();
        if (got.kind !== e.kind) begin
            $error("result_kind: expected %0d, got %0d", e.kind, got.kind); fails++;
        end
        if (got.best !== e.best) begin
            $error("best_cluster: expected %0d, got %0d", e.best, got.best); fails++;
        end
        if (got.rdist !== e.rdist) begin
            $error("row_distance: expected %0d, got %0d", e.rdist, got.rdist); fails++;
        end
        if (got.pen !== e.pen) begin
            $error("row_penalized: expected %0d, got %0d", e.pen, got.pen); fails++;
        end
        if (got.cval !== e.cval) begin
            $error("centroid_value: expected %0d, got %0d", e.cval, got.cval); fails++;
        end
        if (got.fit !== e.fit) begin
            $error("total_fit: expected %0d, got %0d", e.fit, got.fit); fails++;
        end
        if (got.sse !== e.sse) begin
            $error("total_sse: expected %0d, got %0d", e.sse, got.sse); fails++;
        end
        if (got.empty !== e.empty) begin
            $error("empty_clusters: expected %0d, got %0d", e.empty, got.empty); fails++;
        end
    endfunction
endclass

module balanced_kmeans_assign_update_tb;
    logic                              i_clk = 1'b0;
    logic                              i_rst_n = 1'b0;
    logic                              i_valid = 1'b0;
    logic                              o_ready;
    logic [1:0]                        i_kind = bkm_pkg::KIND_LOAD;
    logic [bkm_pkg::CW-1:0]            i_cluster_index = '0;
    logic [bkm_pkg::DW-1:0]            i_dim_index = '0;
    logic signed [bkm_pkg::VAL_W-1:0]  i_value = '0;
    logic                              i_last_in_row = 1'b0;
    logic                              o_valid;
    logic                              i_ready = 1'b0;
    logic [1:0]                        o_result_kind;
    logic [bkm_pkg::CW-1:0]            o_best_cluster;
    logic [bkm_pkg::DIST_W-1:0]        o_row_distance;
    logic [bkm_pkg::PEN_W-1:0]         o_row_penalized;
    logic signed [bkm_pkg::VAL_W-1:0]  o_centroid_value;
    logic [bkm_pkg::TOT_W-1:0]         o_total_fit;
    logic [bkm_pkg::TOT_W-1:0]         o_total_sse;
    logic [bkm_pkg::EMPTY_W-1:0]       o_empty_clusters;
    logic                              psel = 1'b0;
    logic                              penable = 1'b0;
    logic                              pwrite = 1'b0;
    logic [2:0]                        paddr = '0;
    logic [31:0]                       pwdata = '0;
    logic [31:0]                       prdata;
    logic                              pready;

    kmeans_pass_scoreboard sb = new();
    bit                    calm = 1'b0;

    balanced_kmeans_assign_update dut (.*);

    always #10 i_clk = ~i_clk;

    initial begin
        #50_000_000;
        $display("end of test: mismatches");
        $finish;
    end

    // Result side: ready drops in random bursts until the calm last part.
    initial begin
        @(negedge i_clk);
        forever begin
            i_ready <= 1'b1;
            repeat ($urandom_range(1, 30)) @(negedge i_clk);
            if (!calm && $urandom_range(0, 2) == 0) begin
                i_ready <= 1'b0;
                repeat ($urandom_range(1, 13)) @(negedge i_clk);
            end
        end
    end

    always @(posedge i_clk) begin
        t_kmeans_result got;
        if (i_rst_n && o_valid && i_ready) begin
            got = {o_result_kind, o_best_cluster, o_row_distance, o_row_penalized,
                   o_centroid_value, o_total_fit, o_total_sse, o_empty_clusters};
            sb.check_result(got);
        end
    end

    task automatic send_item(logic [1:0] kind, logic [3:0] ci, logic [3:0] di,
                             logic signed [15:0] val, logic last);
        @(negedge i_clk);
        if (!calm && $urandom_range(0, 5) == 0) begin
            i_valid <= 1'b0;
            repeat ($urandom_range(1, 13)) @(negedge i_clk);
        end
        i_valid <= 1'b1;
        i_kind <= kind;
        i_cluster_index <= ci;
        i_dim_index <= di;
        i_value <= val;
        i_last_in_row <= last;
        do @(posedge i_clk); while (!o_ready);
        sb.note_item(kind, ci, di, val, last);
    endtask

    task automatic go_quiet();
        @(negedge i_clk);
        i_valid <= 1'b0;
        while (sb.awaited.size() != 0) @(negedge i_clk);
    endtask

    task automatic write_weight(logic [15:0] w);
        go_quiet();
        repeat (2) @(negedge i_clk);
        psel <= 1'b1;
        pwrite <= 1'b1;
        paddr <= '0;
        pwdata <= {16'd0, w};
        @(negedge i_clk);
        penable <= 1'b1;
        do @(posedge i_clk); while (!pready);
        sb.weight = w;
        @(negedge i_clk);
        psel <= 1'b0;
        penable <= 1'b0;
        pwrite <= 1'b0;
    endtask

    // A row near the given cluster (or anywhere if near is 16); dims in shuffled order.
    task automatic send_row(int near, int elems);
        int               order [bkm_pkg::DIMS];
        int               j, tmp;
        longint           v;
        foreach (order[i]) order[i] = i;
        for (int i = bkm_pkg::DIMS - 1; i > 0; i--) begin
            j = $urandom_range(0, i);
            tmp = order[i];
            order[i] = order[j];
            order[j] = tmp;
        end
        for (int i = 0; i < elems; i++) begin
            if (near < bkm_pkg::CLUSTERS) begin
                v = sb.centroids[near*bkm_pkg::DIMS+order[i]]
                    + $signed($urandom_range(0, 4000)) - 2000;
                if (v > 32767) v = 32767;
                if (v < -32768) v = -32768;
            end else begin
                v = $signed(16'($urandom()));
            end
            send_item(bkm_pkg::KIND_SAMPLE, 4'(near), 4'(order[i]), 16'(v), i == elems - 1);
        end
    endtask

    task automatic random_phase(int items);
        int sent, pick, c, rows;
        sent = 0;
        rows = 0;
        while (sent < items) begin
            pick = $urandom_range(0, 99);
            if (pick < 70) begin
                c = $urandom_range(0, 16);
                pick = ($urandom_range(0, 9) == 0) ? $urandom_range(1, bkm_pkg::DIMS)
                                                    : bkm_pkg::DIMS;
                send_row(c, pick);
                sent += pick;
                rows++;
                if (rows % 14 == 0) begin
                    send_item(bkm_pkg::KIND_END, 4'($urandom()), 4'($urandom()),
                              16'($urandom()), 1'b0);
                    sent++;
                end
            end else if (pick < 82) begin
                send_item(bkm_pkg::KIND_LOAD, 4'($urandom()), 4'($urandom()),
                          16'($urandom()), 1'($urandom()));
                sent++;
            end else if (pick < 96) begin
                send_item(bkm_pkg::KIND_READ, 4'($urandom()), 4'($urandom()),
                          16'($urandom()), 1'($urandom()));
                sent++;
            end else begin
                send_item(bkm_pkg::KIND_END, 4'($urandom()), 4'($urandom()),
                          16'($urandom()), 1'($urandom()));
                sent++;
            end
        end
    endtask

    initial begin
        repeat (3) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;

        // Every centroid element is written before any row or readback uses it.
        // Clusters 2 and 3 are identical, so rows near them test the tie rule.
        for (int c = 0; c < bkm_pkg::CLUSTERS; c++)
            for (int d = 0; d < bkm_pkg::DIMS; d++)
                send_item(bkm_pkg::KIND_LOAD, 4'(c), 4'(d),
                          c == 0 ? 16'sh7FFF : c == 1 ? 16'sh8000 :
                          c == 3 ? 16'(sb.centroids[2*bkm_pkg::DIMS+d]) : 16'($urandom()),
                          1'($urandom()));
        write_weight(16'd0);

        send_item(bkm_pkg::KIND_READ, 4'd0, 4'd15, 16'sd0, 1'b0);
        send_item(bkm_pkg::KIND_READ, 4'd1, 4'd0, 16'sd0, 1'b1);
        for (int d = 0; d < bkm_pkg::DIMS; d++)
            send_item(bkm_pkg::KIND_SAMPLE, 4'd0, 4'(d), 16'sh8000, d == bkm_pkg::DIMS - 1);
        send_row(3, bkm_pkg::DIMS);
        send_item(bkm_pkg::KIND_SAMPLE, 4'd5, 4'd7, 16'sh7FFF, 1'b1);
        send_row(2, bkm_pkg::DIMS);
        send_item(bkm_pkg::KIND_END, 4'd0, 4'd0, 16'sd0, 1'b0);
        send_item(bkm_pkg::KIND_READ, 4'd2, 4'd4, 16'sd0, 1'b0);
        send_item(bkm_pkg::KIND_END, 4'd15, 4'd15, 16'sh7FFF, 1'b1);

        write_weight(16'hFFFF);
        random_phase(230);
        write_weight(16'd256);
        random_phase(230);
        write_weight(16'($urandom()));
        random_phase(230);
        write_weight(16'd1);
        random_phase(230);
        write_weight(16'd0);
        calm = 1'b1;
        random_phase(230);

        go_quiet();
        repeat (500) @(negedge i_clk);
        if (sb.fails == 0 && sb.awaited.size() == 0)
            $display("end of test: clean");
        else
            $display("end of test: mismatches");
        $finish;
    end
endmodule

FILE: files.f
+incdir+hdl
hdl/bkm_pkg.sv
hdl/bkm_div.sv
hdl/bkm_datapath.sv
hdl/bkm_ctrl.sv
hdl/balanced_kmeans_assign_update.sv
dv/balanced_kmeans_assign_update_tb.sv
